@@ hdl/imuagc_pkg.sv @@
// Package for the IMU axis remap and gravity compensation core.
// Holds beat types, register index codes, axis order codes and datapath widths.
// Depends on nothing.
`default_nettype none

package imuagc_pkg;

	// Field widths of the sample and result beats.
	localparam int QW = 16;  // quaternion component, Q2.14
	localparam int AW = 16;  // accelerometer channel, 1/2048 g per LSB
	localparam int GW = 22;  // gravity register, Q6.16 m/s^2
	localparam int OW = 32;  // result component, Q16.16 m/s^2

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = GW;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Z   = 3'd4;

	// Axis orders, named by the axis that channels 0, 1 and 2 land on.
	localparam logic [2:0] AXIS_XYZ = 3'd0;
	localparam logic [2:0] AXIS_XZY = 3'd1;
	localparam logic [2:0] AXIS_YXZ = 3'd2;
	localparam logic [2:0] AXIS_YZX = 3'd3;
	localparam logic [2:0] AXIS_ZXY = 3'd4;
	localparam logic [2:0] AXIS_ZYX = 3'd5;

	localparam logic [2:0] INVERT_RESET = 3'b010;

	// Standard gravity 9.80665 m/s^2 with 16 fraction bits: Q5.16, and Q6.16 as reset value.
	localparam logic signed [20:0] G_Q16 = 21'sd642689;
	localparam logic signed [GW-1:0] GRAVITY_Z_RESET = 22'sd642689;

	// Internal widths, sized from the ranges of the operands.
	localparam int ACC_SHIFT = 11;
	localparam int ACC_PW = AW + 21;              // channel times G_Q16
	localparam int C_W = ACC_PW - ACC_SHIFT;      // scaled channel, Q10.16
	localparam int SQ_W = 2 * QW;
	localparam int K_W = SQ_W + 2;                // w^2 - |u|^2
	localparam int UV_W = QW + GW;
	localparam int D_W = UV_W + 2;                // dot product
	localparam int CR_W = UV_W + 1;               // cross product term
	localparam int KV_W = K_W + GW;
	localparam int DU_W = D_W + QW;
	localparam int WC_W = QW + CR_W;
	localparam int T_W = DU_W + 2;                // rotated gravity, scale 2^44
	localparam int R_SHIFT = 28;
	localparam int R_W = T_W - R_SHIFT;
	localparam int SUM_W = R_W + 1;

	// Cycles from an accepted sample to its result strobe.
	localparam int PIPE_LAT = 5;

	typedef struct packed {
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
		logic signed [QW-1:0] quat_w;
		logic signed [AW-1:0] accel_0;
		logic signed [AW-1:0] accel_1;
		logic signed [AW-1:0] accel_2;
	} sample_t;

	typedef struct packed {
		logic signed [OW-1:0] lin_acc_x;
		logic signed [OW-1:0] lin_acc_y;
		logic signed [OW-1:0] lin_acc_z;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/imu_axis_remap_gravity_comp_core.sv @@
// Top level of the IMU axis remap and gravity compensation core.
// Five-stage pipelined datapath plus the configuration registers.
// Depends on imuagc_pkg.
`default_nettype none

// The core takes one IMU sample beat per clock and returns one result beat
// for each sample taken, marked by a one-cycle done strobe. The sample
// passes through the five register stages of the datapath: products of the
// sample, their sums, the second rank of products, the rounding of the
// rotated gravity vector, and the final add into the output register. Every
// stage advances on every clock, so busy stays low and a new sample may be
// started in each cycle; the result receiver must take each beat in the
// cycle it is shown, since nothing holds it back. The accelerometer
// channels are scaled to Q16.16 m/s^2, permuted by axis_order and negated per
// invert_mask; the gravity registers are rotated by the conjugate of the
// sample quaternion and added. The quaternion is used as given, so a
// non-unit quaternion scales the gravity term by its squared norm. Write the
// configuration registers only while no sample is in flight; a write to an
// index above the register list is ignored.
module imu_axis_remap_gravity_comp_core
	import imuagc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire sample_t               sample,
	output logic                       done,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic signed [ACC_PW-1:0] ROUND_ACC = ACC_PW'(64'sd1 <<< (ACC_SHIFT - 1));
	localparam logic signed [T_W-1:0] ROUND_R = T_W'(64'sd1 <<< (R_SHIFT - 1));

	// Configuration registers.
	logic [2:0]           axis_order_q;
	logic [2:0]           invert_mask_q;
	logic signed [GW-1:0] grav_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_order_q  <= AXIS_YZX;
			invert_mask_q <= INVERT_RESET;
			grav_q[0]     <= '0;
			grav_q[1]     <= '0;
			grav_q[2]     <= GRAVITY_Z_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS_ORDER:  axis_order_q  <= cfg_data[2:0];
				REG_INVERT_MASK: invert_mask_q <= cfg_data[2:0];
				REG_GRAVITY_X:   grav_q[0]     <= cfg_data;
				REG_GRAVITY_Y:   grav_q[1]     <= cfg_data;
				REG_GRAVITY_Z:   grav_q[2]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline never stalls, so a sample is taken whenever start is high.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Valid bits travel alongside the data stages.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Sample fields as small arrays so the stages can loop over axes.
	logic signed [QW-1:0] u_in [3];
	logic signed [AW-1:0] a_in [3];

	assign u_in[0] = sample.quat_x;
	assign u_in[1] = sample.quat_y;
	assign u_in[2] = sample.quat_z;
	assign a_in[0] = sample.accel_0;
	assign a_in[1] = sample.accel_1;
	assign a_in[2] = sample.accel_2;

	// Stage 1: every first-rank product. uv_s1[i][j] is u_i * v_j, which
	// feeds both the dot product and the cross product.
	logic signed [QW-1:0]     u_s1 [3];
	logic signed [QW-1:0]     w_s1;
	logic signed [SQ_W-1:0]   usq_s1 [3];
	logic signed [SQ_W-1:0]   wsq_s1;
	logic signed [UV_W-1:0]   uv_s1 [3][3];
	logic signed [ACC_PW-1:0] acc_s1 [3];

	always_ff @(posedge clk) begin
		w_s1   <= sample.quat_w;
		wsq_s1 <= SQ_W'(sample.quat_w) * SQ_W'(sample.quat_w);
		for (int i = 0; i < 3; i++) begin
			u_s1[i]   <= u_in[i];
			usq_s1[i] <= SQ_W'(u_in[i]) * SQ_W'(u_in[i]);
			acc_s1[i] <= ACC_PW'(a_in[i]) * ACC_PW'(G_Q16);
			for (int j = 0; j < 3; j++) begin
				uv_s1[i][j] <= UV_W'(u_in[i]) * UV_W'(grav_q[j]);
			end
		end
	end

	// Stage 2: the scalar k = w^2 - |u|^2, the dot product, the cross
	// product, and the rounded accelerometer scaling.
	logic signed [QW-1:0]   u_s2 [3];
	logic signed [QW-1:0]   w_s2;
	logic signed [K_W-1:0]  k_s2;
	logic signed [D_W-1:0]  d_s2;
	logic signed [CR_W-1:0] cr_s2 [3];
	logic signed [C_W-1:0]  c_s2 [3];

	always_ff @(posedge clk) begin
		w_s2 <= w_s1;
		k_s2 <= K_W'(wsq_s1) - K_W'(usq_s1[0]) - K_W'(usq_s1[1]) - K_W'(usq_s1[2]);
		d_s2 <= D_W'(uv_s1[0][0]) + D_W'(uv_s1[1][1]) + D_W'(uv_s1[2][2]);
		cr_s2[0] <= CR_W'(uv_s1[1][2]) - CR_W'(uv_s1[2][1]);
		cr_s2[1] <= CR_W'(uv_s1[2][0]) - CR_W'(uv_s1[0][2]);
		cr_s2[2] <= CR_W'(uv_s1[0][1]) - CR_W'(uv_s1[1][0]);
		for (int i = 0; i < 3; i++) begin
			u_s2[i] <= u_s1[i];
			c_s2[i] <= C_W'((acc_s1[i] + ROUND_ACC) >>> ACC_SHIFT);
		end
	end

	// Stage 3: second-rank products k*v, d*u and w*cross.
	logic signed [KV_W-1:0] kv_s3 [3];
	logic signed [DU_W-1:0] du_s3 [3];
	logic signed [WC_W-1:0] wc_s3 [3];
	logic signed [C_W-1:0]  c_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			kv_s3[i] <= KV_W'(k_s2) * KV_W'(grav_q[i]);
			du_s3[i] <= DU_W'(d_s2) * DU_W'(u_s2[i]);
			wc_s3[i] <= WC_W'(w_s2) * WC_W'(cr_s2[i]);
			c_s3[i]  <= c_s2[i];
		end
	end

	// Stage 4: sum and round the rotated gravity vector, and remap the
	// accelerometer axes. An undefined axis order drops the accelerometer.
	logic signed [C_W-1:0] perm_c [3];
	logic signed [T_W-1:0] t_sum [3];

	always_comb begin
		perm_c[0] = '0;
		perm_c[1] = '0;
		perm_c[2] = '0;
		case (axis_order_q)
			AXIS_XYZ: begin
				perm_c[0] = c_s3[0];
				perm_c[1] = c_s3[1];
				perm_c[2] = c_s3[2];
			end
			AXIS_XZY: begin
				perm_c[0] = c_s3[0];
				perm_c[1] = c_s3[2];
				perm_c[2] = c_s3[1];
			end
			AXIS_YXZ: begin
				perm_c[0] = c_s3[1];
				perm_c[1] = c_s3[0];
				perm_c[2] = c_s3[2];
			end
			AXIS_YZX: begin
				perm_c[0] = c_s3[2];
				perm_c[1] = c_s3[0];
				perm_c[2] = c_s3[1];
			end
			AXIS_ZXY: begin
				perm_c[0] = c_s3[1];
				perm_c[1] = c_s3[2];
				perm_c[2] = c_s3[0];
			end
			AXIS_ZYX: begin
				perm_c[0] = c_s3[2];
				perm_c[1] = c_s3[1];
				perm_c[2] = c_s3[0];
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			t_sum[i] = T_W'(kv_s3[i]) + (T_W'(du_s3[i]) <<< 1)
				- (T_W'(wc_s3[i]) <<< 1) + ROUND_R;
		end
	end

	logic signed [R_W-1:0] r_s4 [3];
	logic signed [C_W-1:0] s_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s4[i] <= R_W'(t_sum[i] >>> R_SHIFT);
			s_s4[i] <= invert_mask_q[i] ? -perm_c[i] : perm_c[i];
		end
	end

	// Stage 5: final add into the output register. Both terms are bounded
	// well inside 2^28 in magnitude, so the sum can never reach the 32-bit
	// limits and the saturation reduces to a sign extension.
	logic signed [SUM_W-1:0] sum_c [3];
	result_t                 result_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = SUM_W'(s_s4[i]) + SUM_W'(r_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		result_s5.lin_acc_x <= OW'(sum_c[0]);
		result_s5.lin_acc_y <= OW'(sum_c[1]);
		result_s5.lin_acc_z <= OW'(sum_c[2]);
	end

	assign done   = valid_s5;
	assign result = result_s5;

endmodule

`default_nettype wire

@@ hdl/imuagc_checker.sv @@
// Port-level checker for the IMU axis remap and gravity compensation core,
// with the bind that attaches it to the top level.
// Depends on imuagc_pkg and imu_axis_remap_gravity_comp_core.
`default_nettype none

module imuagc_checker
	import imuagc_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire sample_t sample,
	input wire logic    done,
	input wire result_t result
);

	// Every accepted sample beat yields a result beat after the fixed latency.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted sample produced no result beat");

	// No result beat appears without a sample accepted the latency before.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result beat without a matching sample");

	// A zero quaternion and zero accelerometer reading give a zero result
	// under any configuration.
	a_zero_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sample == '0) |-> ##PIPE_LAT (done && result == '0))
		else $error("zero sample produced a nonzero result");

	// The pipeline takes a beat every cycle and never signals busy.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind imu_axis_remap_gravity_comp_core imuagc_checker u_checker (.*);

`default_nettype wire
